[src/sla_pkg.sv]
// Package for the skyline lightmap allocator.
// Word types, action and status codes shared by the core and the top level.
// No dependencies.
package sla_pkg;

  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  localparam logic [1:0] ST_PLACED    = 2'd0;
  localparam logic [1:0] ST_DONE      = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_NOFIT     = 2'd3;

  typedef struct packed {
    logic        action;
    logic [10:0] extent_s;
    logic [10:0] extent_t;
    logic        skip_surface;
  } sla_in_t;

  typedef struct packed {
    logic [6:0]  pos_x;
    logic [6:0]  pos_y;
    logic [3:0]  page_index;
    logic [15:0] byte_offset;
    logic [1:0]  status;
  } sla_out_t;

endpackage

[src/sla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/sla_core.sv]
// Sequencer and shared compare unit of the skyline allocator.
// Scans windows through the column height RAM, one height per cycle within a window.
// Depends on sla_pkg.
module sla_core #(
  parameter int COLUMNS         = 128,
  parameter int ROWS            = 128,
  parameter int PAGES           = 16,
  parameter int BYTES_PER_TEXEL = 4
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  input  sla_pkg::sla_in_t                            in_data,
  output logic                                        in_ready,
  output logic                                        res_valid,
  output sla_pkg::sla_out_t                           res_data,
  input  logic                                        res_take,
  output logic                                        ram_we,
  output logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0] ram_waddr,
  output logic [$clog2(ROWS + 1)-1:0]                 ram_wdata,
  output logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0] ram_raddr,
  input  logic [$clog2(ROWS + 1)-1:0]                 ram_rdata
);

  import sla_pkg::*;

  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int HW = $clog2(ROWS + 1);
  localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int LW = ((CW + 1) > 9) ? (CW + 1) : 9;
  localparam int SW = ((HW > 8) ? HW : 8) + 1;
  localparam logic [LW-1:0] COLS_L  = LW'(COLUMNS);
  localparam logic [SW-1:0] ROWS_S  = SW'(ROWS);
  localparam logic [HW-1:0] ROWS_H  = HW'(ROWS);
  localparam logic [PW:0]   PAGES_P = (PW + 1)'(PAGES);
  localparam logic [CW-1:0] LAST_C  = CW'(COLUMNS - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_WRITE  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [7:0]      j_r, j_nxt;
  logic            rdv_r, rdv_nxt;
  logic [HW-1:0]   peak_r, peak_nxt;
  logic [HW-1:0]   best_r, best_nxt;
  logic [CW-1:0]   bx_r, bx_nxt;
  logic            found_r, found_nxt;
  logic [7:0]      w_r, w_nxt;
  logic [7:0]      h_r, h_nxt;
  logic [PW-1:0]   page_r, page_nxt;
  logic            retry_r, retry_nxt;
  logic            begin_r, begin_nxt;
  logic [CW-1:0]   clr_r, clr_nxt;
  logic [15:0]     lin_r, lin_nxt;
  sla_out_t        res_r, res_nxt;

  logic [7:0]      w_in, h_in, scan_w;
  logic            start_scan;
  logic            brk, last_j;
  logic [HW-1:0]   peak_new;
  logic [LW-1:0]   lim, i_inc;
  logic [SW-1:0]   top_s;
  logic [31:0]     lin_full, off_full;

  assign w_in     = 8'(in_data.extent_s[10:4]) + 8'd1;
  assign h_in     = 8'(in_data.extent_t[10:4]) + 8'd1;
  assign brk      = rdv_r && (ram_rdata >= best_r);
  assign last_j   = rdv_r && !brk && (j_r == w_r);
  assign peak_new = (rdv_r && (ram_rdata > peak_r)) ? ram_rdata : peak_r;
  assign lim      = COLS_L - LW'(w_r);
  assign i_inc    = LW'(i_r) + LW'(1);
  assign top_s    = SW'(best_r) + SW'(h_r);
  assign lin_full = 32'(best_r) * 32'(COLUMNS) + 32'(bx_r);
  assign off_full = 32'(lin_r) * 32'(BYTES_PER_TEXEL);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FINISH);
  assign res_data  = res_r;

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    rdv_nxt    = 1'b0;
    peak_nxt   = peak_r;
    best_nxt   = best_r;
    bx_nxt     = bx_r;
    found_nxt  = found_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    page_nxt   = page_r;
    retry_nxt  = retry_r;
    begin_nxt  = begin_r;
    clr_nxt    = clr_r;
    lin_nxt    = lin_r;
    res_nxt    = res_r;
    ram_we     = 1'b0;
    ram_waddr  = clr_r;
    ram_wdata  = '0;
    ram_raddr  = i_r + CW'(j_r);
    start_scan = 1'b0;
    scan_w     = w_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + CW'(1);
        if (clr_r == LAST_C) begin
          if (retry_r) begin
            start_scan = 1'b1;
          end else if (begin_r) begin
            res_nxt        = '0;
            res_nxt.status = ST_DONE;
            state_nxt      = S_FINISH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.action == ACT_BEGIN) begin
            page_nxt  = '0;
            begin_nxt = 1'b1;
            retry_nxt = 1'b0;
            clr_nxt   = '0;
            state_nxt = S_CLEAR;
          end else if (in_data.skip_surface) begin
            res_nxt        = '0;
            res_nxt.status = ST_DONE;
            state_nxt      = S_FINISH;
          end else begin
            w_nxt      = w_in;
            h_nxt      = h_in;
            scan_w     = w_in;
            retry_nxt  = 1'b0;
            begin_nxt  = 1'b0;
            start_scan = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (brk || last_j) begin
          if (last_j) begin
            bx_nxt    = i_r;
            best_nxt  = peak_new;
            found_nxt = 1'b1;
          end
          peak_nxt = '0;
          j_nxt    = '0;
          if (i_inc >= lim) begin
            state_nxt = S_DECIDE;
          end else begin
            i_nxt = CW'(i_inc);
          end
        end else begin
          peak_nxt = peak_new;
          j_nxt    = j_r + 8'd1;
          rdv_nxt  = 1'b1;
        end
      end
      S_DECIDE: begin
        if (found_r && (top_s <= ROWS_S)) begin
          lin_nxt   = lin_full[15:0];
          j_nxt     = '0;
          state_nxt = S_WRITE;
        end else if (retry_r) begin
          res_nxt        = '0;
          res_nxt.status = ST_NOFIT;
          state_nxt      = S_FINISH;
        end else if (({1'b0, page_r} + (PW + 1)'(1)) >= PAGES_P) begin
          res_nxt        = '0;
          res_nxt.status = ST_EXHAUSTED;
          state_nxt      = S_FINISH;
        end else begin
          page_nxt  = page_r + PW'(1);
          retry_nxt = 1'b1;
          clr_nxt   = '0;
          state_nxt = S_CLEAR;
        end
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = bx_r + CW'(j_r);
        ram_wdata = HW'(top_s);
        j_nxt     = j_r + 8'd1;
        if (j_r == (w_r - 8'd1)) begin
          res_nxt.pos_x       = 7'(bx_r);
          res_nxt.pos_y       = 7'(best_r);
          res_nxt.page_index  = 4'(page_r);
          res_nxt.byte_offset = off_full[15:0];
          res_nxt.status      = ST_PLACED;
          state_nxt           = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_take) begin
          begin_nxt = 1'b0;
          retry_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (start_scan) begin
      i_nxt     = '0;
      j_nxt     = '0;
      peak_nxt  = '0;
      best_nxt  = ROWS_H;
      found_nxt = 1'b0;
      if (LW'(scan_w) >= COLS_L) begin
        state_nxt = S_DECIDE;
      end else begin
        state_nxt = S_SCAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      rdv_r   <= 1'b0;
      page_r  <= '0;
      retry_r <= 1'b0;
      begin_r <= 1'b0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= rdv_nxt;
      page_r  <= page_nxt;
      retry_r <= retry_nxt;
      begin_r <= begin_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    peak_r  <= peak_nxt;
    best_r  <= best_nxt;
    bx_r    <= bx_nxt;
    found_r <= found_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    lin_r   <= lin_nxt;
    res_r   <= res_nxt;
  end

endmodule

[src/skyline_lightmap_allocator.sv]
// Skyline lightmap allocator: a skip goes straight to the result and a begin first clears the
// height RAM; an allocate scans start columns (a window may stop early), decides and writes w
// heights when placed, then gives the result; a page advance adds a clear and a second scan.
// One word in flight: in_ready rises with out_valid, as the result enters the output register.
// Reset (synchronous, rst_n low) zeroes the page and runs a clear of every column of
// the height RAM, during which in_ready stays low.
module skyline_lightmap_allocator #(
  parameter int COLUMNS         = 128,
  parameter int ROWS            = 128,
  parameter int PAGES           = 16,
  parameter int BYTES_PER_TEXEL = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sla_pkg::sla_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sla_pkg::sla_out_t out_data
);

  import sla_pkg::*;

  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int HW = $clog2(ROWS + 1);

  logic          res_valid, res_take;
  sla_out_t      res_data;
  logic          ram_we;
  logic [CW-1:0] ram_waddr, ram_raddr;
  logic [HW-1:0] ram_wdata, ram_rdata;
  logic          out_valid_r, out_valid_nxt;
  sla_out_t      out_data_r, out_data_nxt;

  sla_ram #(
    .WIDTH (HW),
    .DEPTH (COLUMNS)
  ) u_heights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sla_core #(
    .COLUMNS         (COLUMNS),
    .ROWS            (ROWS),
    .PAGES           (PAGES),
    .BYTES_PER_TEXEL (BYTES_PER_TEXEL)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  assign res_take      = res_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = res_take || (out_valid_r && !out_ready);
  assign out_data_nxt  = res_take ? res_data : out_data_r;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_PLACED) |->
      (out_data.pos_x == '0) && (out_data.pos_y == '0) &&
      (out_data.page_index == '0) && (out_data.byte_offset == '0))
    else $error("non-placed word carries position data");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accepting a word");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a busy cycle");

endmodule

[tb/sla_result_checker.sv]
// Result checker for the skyline lightmap allocator.
// Watches both word channels, predicts each result from its own skyline copy and
// compares it field by field. Depends on sla_pkg.
module sla_result_checker #(
  parameter int COLUMNS         = 128,
  parameter int ROWS            = 128,
  parameter int PAGES           = 16,
  parameter int BYTES_PER_TEXEL = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  sla_pkg::sla_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  sla_pkg::sla_out_t out_data,
  output int                fail_count,
  output int                pending,
  output int                checked
);
  import sla_pkg::*;

  int       sky_height [COLUMNS];
  int       atlas_page;
  sla_out_t expected_words [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic void flatten_skyline();
    for (int c = 0; c < COLUMNS; c++) sky_height[c] = 0;
  endfunction

  // Lowest-peak window search; first window scanned wins ties, last column never starts one.
  function automatic bit fit_rect(input int wd, input int ht, output int px, output int py);
    int best;
    int bx;
    bit found;
    int peak;
    int j;
    best  = ROWS;
    bx    = 0;
    found = 1'b0;
    px    = 0;
    py    = 0;
    if (wd < COLUMNS) begin
      for (int i = 0; i < COLUMNS - wd; i++) begin
        peak = 0;
        for (j = 0; j < wd; j++) begin
          if (sky_height[i + j] >= best) break;
          if (sky_height[i + j] > peak) peak = sky_height[i + j];
        end
        if (j == wd) begin
          bx    = i;
          best  = peak;
          found = 1'b1;
        end
      end
    end
    if (!found || best + ht > ROWS) return 1'b0;
    for (j = 0; j < wd; j++) sky_height[bx + j] = best + ht;
    px = bx;
    py = best;
    return 1'b1;
  endfunction

  function automatic sla_out_t predict_placement(sla_in_t word);
    sla_out_t r;
    int       px;
    int       py;
    int       wd;
    int       ht;
    r        = '0;
    r.status = ST_DONE;
    if (word.action == ACT_BEGIN) begin
      flatten_skyline();
      atlas_page = 0;
      return r;
    end
    if (word.skip_surface) return r;
    wd = int'(word.extent_s >> 4) + 1;
    ht = int'(word.extent_t >> 4) + 1;
    if (!fit_rect(wd, ht, px, py)) begin
      if (atlas_page + 1 >= PAGES) begin
        r.status = ST_EXHAUSTED;
        return r;
      end
      atlas_page++;
      flatten_skyline();
      if (!fit_rect(wd, ht, px, py)) begin
        r.status = ST_NOFIT;
        return r;
      end
    end
    r.pos_x       = 7'(px);
    r.pos_y       = 7'(py);
    r.page_index  = 4'(atlas_page);
    r.byte_offset = 16'((py * COLUMNS + px) * BYTES_PER_TEXEL);
    r.status      = ST_PLACED;
    return r;
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    sla_out_t want;
    if (!rst_n) begin
      flatten_skyline();
      atlas_page = 0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with none pending: %p", out_data);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("pos_x", want.pos_x, out_data.pos_x);
          check_field("pos_y", want.pos_y, out_data.pos_y);
          check_field("page_index", want.page_index, out_data.page_index);
          check_field("byte_offset", want.byte_offset, out_data.byte_offset);
          check_field("status", want.status, out_data.status);
          checked++;
        end
      end
      if (in_valid && in_ready) expected_words.push_back(predict_placement(in_data));
    end
    pending = expected_words.size();
  end

endmodule

[tb/tb_skyline_lightmap_allocator.sv]
// Testbench top for the skyline lightmap allocator.
// Drives directed and random words with bursty valid and a stalling receiver;
// checking is done by sla_result_checker. Depends on sla_pkg and the block.
module tb_skyline_lightmap_allocator;
  import sla_pkg::*;

  localparam int RUN_LIMIT = 80_000_000;

  typedef enum {RX_OPEN, RX_COIN, RX_CADENCE, RX_TRICKLE} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sla_in_t  in_data;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sla_out_t out_data;

  int       fail_count;
  int       pending;
  int       checked;
  int       n_begin;
  int       n_skip;
  int       n_alloc;
  int       burst_left;
  int       n_random;
  rx_mode_t rx_mode = RX_OPEN;
  int       mode_left = 0;

  always #4 clk = ~clk;

  skyline_lightmap_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sla_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(16, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RX_CADENCE:  out_ready <= (mode_left % 5) < 2;
      default:     out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic sla_in_t make_word(logic act, int es, int et, logic skip);
    sla_in_t word;
    word.action       = act;
    word.extent_s     = 11'(es);
    word.extent_t     = 11'(et);
    word.skip_surface = skip;
    return word;
  endfunction

  // Mostly small rectangles; large ones are slow to scan.
  function automatic int pick_extent();
    int c;
    c = $urandom_range(0, 99);
    if (c < 65) return $urandom_range(0, 255);
    if (c < 88) return $urandom_range(256, 1023);
    return $urandom_range(1024, 2047);
  endfunction

  task automatic send_word(sla_in_t word);
    int gap;
    in_data  = word;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (word.action == ACT_BEGIN) n_begin++;
    else if (word.skip_surface) n_skip++;
    else n_alloc++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int run;
    int roll;
    in_valid   = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    burst_left = 0;
    n_begin    = 0;
    n_skip     = 0;
    n_alloc    = 0;
    n_random   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // begin ignores extents and skip flag
    send_word(make_word(ACT_BEGIN, 2047, 2047, 1'b1));
    send_word(make_word(ACT_ALLOC, 0, 0, 1'b0));
    send_word(make_word(ACT_ALLOC, 16, 0, 1'b0));
    send_word(make_word(ACT_ALLOC, 2047, 2047, 1'b1));
    send_word(make_word(ACT_ALLOC, 1000, 2047, 1'b0));
    send_word(make_word(ACT_ALLOC, 0, 2032, 1'b0));
    // window as wide as the page: advance, clear, still no fit
    send_word(make_word(ACT_ALLOC, 2047, 0, 1'b0));
    // widest window that still has a start column, full height
    send_word(make_word(ACT_ALLOC, 2031, 2047, 1'b0));
    send_word(make_word(ACT_ALLOC, 0, 0, 1'b0));
    send_word(make_word(ACT_ALLOC, 'h555, 'h2AA, 1'b0));
    // lowest peak plus height overflows the rows
    send_word(make_word(ACT_ALLOC, 'h2AA, 'h555, 1'b0));
    // walk the pages up to exhaustion, then past it
    for (int i = 0; i < 14; i++) send_word(make_word(ACT_ALLOC, 2032 + i, i * 100, 1'b0));
    send_word(make_word(ACT_ALLOC, 'h0F, 'h7F0, 1'b0));
    send_word(make_word(ACT_BEGIN, 0, 0, 1'b0));
    drain_results();

    while (n_random < 75) begin
      send_word(make_word(ACT_BEGIN, $urandom_range(0, 2047), $urandom_range(0, 2047),
                          1'($urandom_range(0, 1))));
      n_random++;
      run = $urandom_range(6, 30);
      if (run > 75 - n_random) run = 75 - n_random;
      repeat (run) begin
        roll = $urandom_range(0, 99);
        if (roll < 4)
          send_word(make_word(ACT_BEGIN, pick_extent(), pick_extent(), 1'($urandom_range(0, 1))));
        else if (roll < 12)
          send_word(make_word(ACT_ALLOC, pick_extent(), pick_extent(), 1'b1));
        else if (roll < 15)
          send_word(make_word(ACT_ALLOC, $urandom_range(2032, 2047), pick_extent(), 1'b0));
        else
          send_word(make_word(ACT_ALLOC, pick_extent(), pick_extent(), 1'b0));
        n_random++;
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    drain_results();
    repeat (200) @(negedge clk);
    $display("Sent %0d words: %0d begin, %0d skipped, %0d allocate; %0d results checked",
             n_begin + n_skip + n_alloc, n_begin, n_skip, n_alloc, checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/sla_pkg.sv
src/sla_ram.sv
src/sla_core.sv
src/skyline_lightmap_allocator.sv
tb/sla_result_checker.sv
tb/tb_skyline_lightmap_allocator.sv
